@@ rtl/laser_scan_to_points_macros.svh @@
// Assertion macros used by the checker file of the laser scan converter.
`ifndef LASER_SCAN_TO_POINTS_MACROS_SVH
`define LASER_SCAN_TO_POINTS_MACROS_SVH

// Concurrent assertion on the rising clock, switched off while reset is held.
`define LSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent assertion on the rising clock that also holds through reset.
`define LSP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/lsp_pkg.sv @@
// Shared constants, register codes and sine table math for the laser scan converter.
package lsp_pkg;

  localparam int unsigned SineEntriesDef = 1024;
  localparam int unsigned RangeBitsDef   = 16;
  localparam int unsigned CfgW           = 16;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned PhaseW         = 16;
  localparam int unsigned SineMagW       = 15;
  localparam int unsigned CoordW         = 17;
  localparam int unsigned OutDataW       = 40;

  localparam logic [CfgW-1:0]     RangeUpperRst = 16'hFFFF;
  localparam logic [SineMagW-1:0] FullScale     = 15'h7FFF;
  localparam logic [15:0]         MagMax        = 16'hFFFF;
  localparam logic [63:0]         PiQ40         = 64'h0000_0324_3F6A_8886;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_ANGLE_START,
    REG_ANGLE_STEP,
    REG_RANGE_LOWER,
    REG_RANGE_UPPER
  } cfg_reg_e;

  // Product of two Q40 values, kept in Q40.
  function automatic logic [63:0] mul_q40(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[103:40];
  endfunction

  // Q0.15 sine of an angle x given in Q40 radians, by a Taylor series.
  function automatic logic [SineMagW-1:0] sine_q15(logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    x2   = mul_q40(x, x);
    term = x;
    sum  = signed'(x);
    term = mul_q40(term, x2) / 64'd6;   sum = sum - signed'(term);
    term = mul_q40(term, x2) / 64'd20;  sum = sum + signed'(term);
    term = mul_q40(term, x2) / 64'd42;  sum = sum - signed'(term);
    term = mul_q40(term, x2) / 64'd72;  sum = sum + signed'(term);
    term = mul_q40(term, x2) / 64'd110; sum = sum - signed'(term);
    term = mul_q40(term, x2) / 64'd156; sum = sum + signed'(term);
    term = mul_q40(term, x2) / 64'd210; sum = sum - signed'(term);
    term = mul_q40(term, x2) / 64'd272; sum = sum + signed'(term);
    term = mul_q40(term, x2) / 64'd342; sum = sum - signed'(term);
    term = mul_q40(term, x2) / 64'd420; sum = sum + signed'(term);
    term = mul_q40(term, x2) / 64'd506; sum = sum - signed'(term);
    term = mul_q40(term, x2) / 64'd600; sum = sum + signed'(term);
    if (sum < 0) begin
      sum = '0;
    end
    v = ((unsigned'(sum) << 15) + (64'd1 << 39)) >> 40;
    return (v > 64'(FullScale)) ? FullScale : v[SineMagW-1:0];
  endfunction

endpackage

@@ rtl/laser_scan_to_points.sv @@
// Top level of the laser scan converter: range samples in, cartesian points out.
//
// Usage:
// - Slave stream: tdata carries the range sample in millimetres, tuser[0] is set
//   for a finite sample, tlast marks the last sample of a scan.
// - Master stream: tdata carries x then y (17-bit signed each, from bit 0), tuser[0]
//   flags a valid point, tlast repeats the scan end of the sample.
// - Configuration: write start angle, angle step and the two range limits through
//   cfg_we_i / cfg_idx_i / cfg_wdata_i while no sample is in flight.
// - Throughput is one sample per cycle while the receiver does not stall. The sine
//   table read and the stage 1 registers are loaded at the sample transfer edge, the
//   products are registered in stage 2, and the rounded point in stage 3, which offers it.
// - After reset the quarter-wave sine table is loaded into its RAM, one entry a
//   cycle; s_tready_o stays low meanwhile. Reset also clears the beam phase, so the
//   next sample starts a scan.
// - When the receiver stalls, results back up through the three stages and
//   s_tready_o drops only when all of them hold a point.
module laser_scan_to_points #(
  parameter int unsigned SINE_TABLE_ENTRIES = lsp_pkg::SineEntriesDef,
  parameter int unsigned RANGE_BITS         = lsp_pkg::RangeBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [lsp_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [lsp_pkg::CfgW-1:0]             cfg_wdata_i,
  // Sample stream.
  input  logic                                 s_tvalid_i,
  output logic                                 s_tready_o,
  input  logic [((RANGE_BITS+7)/8)*8-1:0]      s_tdata_i,  // range_sample
  input  logic [0:0]                           s_tuser_i,  // sample_finite
  input  logic                                 s_tlast_i,
  // Point stream.
  output logic                                 m_tvalid_o,
  input  logic                                 m_tready_i,
  output logic [lsp_pkg::OutDataW-1:0]         m_tdata_o,  // x_coord, y_coord
  output logic [0:0]                           m_tuser_o,  // point_valid
  output logic                                 m_tlast_o
);

  localparam int unsigned AW      = $clog2(SINE_TABLE_ENTRIES);
  localparam int unsigned QW      = 14;
  localparam int unsigned JProdW  = QW + $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int unsigned MagW    = lsp_pkg::SineMagW;
  localparam int unsigned ProdW   = RANGE_BITS + MagW;
  localparam int unsigned CmpW    = (RANGE_BITS > 16) ? RANGE_BITS : 16;
  localparam int unsigned CoordW  = lsp_pkg::CoordW;
  localparam int unsigned PadW    = lsp_pkg::OutDataW - 2 * CoordW;
  localparam logic [ProdW-1:0] RoundHalf = ProdW'(16384);

  // Constant quarter-wave table used to load the RAM after reset.
  logic [MagW-1:0] fill_rom [SINE_TABLE_ENTRIES];

  for (genvar gi = 0; gi < SINE_TABLE_ENTRIES; gi++) begin : g_rom
    localparam logic [63:0] Ang = (lsp_pkg::PiQ40 * 64'(gi)) / 64'(2 * SINE_TABLE_ENTRIES);
    assign fill_rom[gi] = lsp_pkg::sine_q15(Ang);
  end

  // Table load sequencer.
  logic          fill_q;
  logic [AW-1:0] fill_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= 1'b1;
      fill_cnt_q <= '0;
    end else if (fill_q) begin
      fill_cnt_q <= fill_cnt_q + 1'b1;
      if (fill_cnt_q == AW'(SINE_TABLE_ENTRIES - 1)) begin
        fill_q <= 1'b0;
      end
    end
  end

  // Configuration registers.
  logic [lsp_pkg::PhaseW-1:0] angle_start_q, angle_step_q;
  logic [lsp_pkg::CfgW-1:0]   range_lower_q, range_upper_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_start_q <= '0;
      angle_step_q  <= '0;
      range_lower_q <= '0;
      range_upper_q <= lsp_pkg::RangeUpperRst;
    end else if (cfg_we_i) begin
      unique case (lsp_pkg::cfg_reg_e'(cfg_idx_i))
        lsp_pkg::REG_ANGLE_START: angle_start_q <= cfg_wdata_i;
        lsp_pkg::REG_ANGLE_STEP:  angle_step_q  <= cfg_wdata_i;
        lsp_pkg::REG_RANGE_LOWER: range_lower_q <= cfg_wdata_i;
        lsp_pkg::REG_RANGE_UPPER: range_upper_q <= cfg_wdata_i;
      endcase
    end
  end

  // Stage flow control: each stage moves when the next one is empty or moving.
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;
  logic in_xfer;

  assign adv3       = !v3_q || m_tready_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign s_tready_o = adv1 && !fill_q;
  assign in_xfer    = s_tvalid_i && s_tready_o;

  // Beam phase accumulator.
  logic [lsp_pkg::PhaseW-1:0] beam_phase_q, phase_d;
  logic                       scan_running_q;

  assign phase_d = scan_running_q ? (beam_phase_q + angle_step_q) : angle_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_phase_q   <= '0;
      scan_running_q <= 1'b0;
    end else if (in_xfer) begin
      beam_phase_q   <= phase_d;
      scan_running_q <= !s_tlast_i;
    end
  end

  // Table addresses: sine and cosine share the index within the quadrant,
  // so one port reads T[j] and the other the mirrored entry T[N-j].
  logic [JProdW-1:0]     jprod;
  logic [AW-1:0]         tab_j, tab_m;
  logic                  j_zero;
  logic [RANGE_BITS-1:0] range_in;
  logic                  ok_in;

  assign jprod  = JProdW'(phase_d[QW-1:0]) * JProdW'(SINE_TABLE_ENTRIES);
  assign tab_j  = AW'(jprod >> QW);
  assign j_zero = (tab_j == '0);
  assign tab_m  = j_zero ? '0 : AW'((AW+1)'(SINE_TABLE_ENTRIES) - (AW+1)'(tab_j));

  // Range gate against the configured limits.
  assign range_in = s_tdata_i[RANGE_BITS-1:0];
  assign ok_in    = s_tuser_i[0] && (CmpW'(range_in) > CmpW'(range_lower_q))
                                 && (CmpW'(range_in) < CmpW'(range_upper_q));

  logic [MagW-1:0] rd_j, rd_m;

  lsp_ram #(
    .WIDTH (MagW),
    .DEPTH (SINE_TABLE_ENTRIES)
  ) u_sine_ram (
    .clk_i     (clk_i),
    .we_i      (fill_q),
    .waddr_i   (fill_cnt_q),
    .wdata_i   (fill_rom[fill_cnt_q]),
    .re_i      (in_xfer),
    .raddr_a_i (tab_j),
    .raddr_b_i (tab_m),
    .rdata_a_o (rd_j),
    .rdata_b_o (rd_m)
  );

  // Stage 1 registers, aligned with the table read.
  logic [RANGE_BITS-1:0] r1_q;
  logic                  ok1_q, last1_q, jz1_q;
  logic [1:0]            quad1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv1) begin
      v1_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      r1_q    <= range_in;
      ok1_q   <= ok_in;
      last1_q <= s_tlast_i;
      jz1_q   <= j_zero;
      quad1_q <= phase_d[lsp_pkg::PhaseW-1 -: 2];
    end
  end

  // Quadrant folding and the two multipliers.
  logic [MagW-1:0]  mirror_mag, sin_mag, cos_mag;
  logic [1:0]       quad_c;
  logic [ProdW-1:0] prod_x, prod_y;

  assign mirror_mag = jz1_q ? lsp_pkg::FullScale : rd_m;
  assign quad_c     = quad1_q + 2'd1;
  assign sin_mag    = quad1_q[0] ? mirror_mag : rd_j;
  assign cos_mag    = quad_c[0] ? mirror_mag : rd_j;
  assign prod_x     = ProdW'(r1_q) * ProdW'(cos_mag);
  assign prod_y     = ProdW'(r1_q) * ProdW'(sin_mag);

  // Stage 2 registers: products and signs.
  logic [ProdW-1:0] px2_q, py2_q;
  logic             nx2_q, ny2_q, ok2_q, last2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      px2_q   <= prod_x;
      py2_q   <= prod_y;
      nx2_q   <= quad_c[1];
      ny2_q   <= quad1_q[1];
      ok2_q   <= ok1_q;
      last2_q <= last1_q;
    end
  end

  // Round half away from zero, saturate, apply sign, zero out invalid points.
  function automatic logic [CoordW-1:0] coord_of(logic [ProdW-1:0] prod, logic neg, logic ok);
    logic [ProdW-1:0]      rsum;
    logic [RANGE_BITS-1:0] rnd;
    logic [15:0]           mag;
    logic [CoordW-1:0]     val;
    rsum = prod + RoundHalf;
    rnd  = rsum[ProdW-1:MagW];
    mag  = (CmpW'(rnd) > CmpW'(lsp_pkg::MagMax)) ? lsp_pkg::MagMax : 16'(rnd);
    val  = {1'b0, mag};
    if (!ok) begin
      val = '0;
    end else if (neg) begin
      val = -val;
    end
    return val;
  endfunction

  // Stage 3: output register.
  logic [CoordW-1:0] x3_q, y3_q;
  logic              ok3_q, last3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3 && v2_q) begin
      x3_q    <= coord_of(px2_q, nx2_q, ok2_q);
      y3_q    <= coord_of(py2_q, ny2_q, ok2_q);
      ok3_q   <= ok2_q;
      last3_q <= last2_q;
    end
  end

  assign m_tvalid_o = v3_q;
  assign m_tdata_o  = {{PadW{1'b0}}, y3_q, x3_q};
  assign m_tuser_o  = ok3_q;
  assign m_tlast_o  = last3_q;

endmodule

@@ rtl/lsp_ram.sv @@
// Generic RAM with one write port and two registered read ports.
module lsp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read ports, held while no read is requested.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

@@ rtl/lsp_checker.sv @@
// Port-level checks of the laser scan converter and their binding to the top level.
`include "laser_scan_to_points_macros.svh"

module lsp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_tready_i,
  input logic                         m_tvalid_i,
  input logic                         m_tready_i,
  input logic [lsp_pkg::OutDataW-1:0] m_tdata_i,
  input logic [0:0]                   m_tuser_i,
  input logic                         m_tlast_i
);

  // A stalled point holds until its transfer.
  `LSP_ASSERT(a_out_hold, (m_tvalid_i && !m_tready_i) |=> (m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i) && $stable(m_tlast_i)), "point changed while stalled")

  // An invalid point carries zero coordinates.
  `LSP_ASSERT(a_invalid_zero, (m_tvalid_i && !m_tuser_i[0]) |-> (m_tdata_i[33:0] == '0), "invalid point with nonzero coordinates")

  // Coordinates stay within the saturated magnitude.
  `LSP_ASSERT(a_coord_range, m_tvalid_i |-> ((m_tdata_i[16:0] != 17'h10000) && (m_tdata_i[33:17] != 17'h10000)), "coordinate beyond saturation limit")

  // The table load after reset keeps the sample side closed.
  `LSP_ASSERT_RST(a_reset_closed, !rst_ni |=> !s_tready_i, "sample accepted during table load")

endmodule

bind laser_scan_to_points lsp_checker u_lsp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tready_i (s_tready_o),
  .m_tvalid_i (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_i  (m_tdata_o),
  .m_tuser_i  (m_tuser_o),
  .m_tlast_i  (m_tlast_o)
);
